@@ hw/rtl/lpba_pkg.sv @@
// shared types and constants for the lidar point box assignment block
// no dependencies; used by every module of the block
`default_nettype none

package lpba_pkg;

  localparam int MAX_BOXES_DEF = 32;

  localparam int COEF_W   = 32;
  localparam int CIDX_W   = 4;
  localparam int NUM_COEF = 12;
  localparam int PT_W     = 32;
  localparam int SF_W     = 16;
  localparam int SLOT_W   = 5;
  localparam int EDGE_W   = 14;
  localparam int DIM_W    = 12;
  localparam int PIX_W    = 16;
  localparam int CNT_W    = 6;
  localparam int CNT_MAX  = 2**CNT_W - 1;
  localparam int IDX_W    = 5;

  // row sums of the projection, floored q32.16 products plus offset
  localparam int YW = 50;
  // quotient bits: 16 magnitude bits plus one overflow bit
  localparam int QW = 17;

  localparam int PROJ_LAT = 2;
  localparam int DIV_LAT  = QW + 2;

  localparam logic [SF_W-1:0] SHRINK_RST = 16'd6554;

  typedef enum logic [1:0] {
    OP_LOAD_COEF = 2'd0,
    OP_LOAD_BOX  = 2'd1,
    OP_POINT     = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_NONE       = 2'd0,
    ST_ONE        = 2'd1,
    ST_MULTI      = 2'd2,
    ST_ZERO_DEPTH = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0] left;
    logic signed [EDGE_W-1:0] top;
    logic [DIM_W-1:0]         width;
    logic [DIM_W-1:0]         height;
  } box_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    box_t              box;
  } box_wr_t;

endpackage

`default_nettype wire

@@ hw/rtl/lidar_point_box_assign.sv @@
// top level of the lidar point box assignment block: stream ports, register
// port, box shrink stages and the result register; depends on lpba_pkg,
// lpba_proj, lpba_div and lpba_boxes
//
//  channel  | ports                    | beat content
//  ---------+--------------------------+-----------------------------------------
//  input    | in_tvalid/tready/tdata   | load coefficient, load box or point
//  result   | out_tvalid/tready/tdata  | pixel, box index, count; status in tuser
//  config   | cfg_psel .. cfg_pready   | shrink_factor at 0x0, box_count at 0x4
//
// one beat enters per cycle while the result register is free or being taken;
// a point passes the multiplier stages and then the 17-step pipelined divider
// every stage advances together when the result register is free or being
// taken, so a stall freezes the whole pipeline and drops nothing
// rst_n clears the coefficients, box_count and all valid bits, sets shrink_factor
// to its reset value; the box table holds garbage until a box is loaded into it
`default_nettype none

module lidar_point_box_assign #(
  parameter int MAX_BOXES = lpba_pkg::MAX_BOXES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // coeff_index[3:0], coeff_value[35:4], box_slot[40:36], box_x[53:41],
  // box_y[66:54], box_width[78:67], box_height[90:79], point_x[122:91],
  // point_y[154:123], point_z[186:155], zero fill [191:187]
  input  wire logic [191:0] in_tdata,
  // opcode[1:0]
  input  wire logic [1:0]   in_tuser,
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pixel_x[15:0], pixel_y[31:16], box_index[36:32], enclosing_count[42:37],
  // zero fill [47:43]
  output logic [47:0]       out_tdata,
  // status[1:0]
  output logic [1:0]        out_tuser,
  // register port
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import lpba_pkg::*;

  localparam logic REG_SHRINK = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  // sideband line runs alongside the projection and divider stages
  localparam int SIDE_N = PROJ_LAT + DIV_LAT - 1;
  localparam int FRAC   = 17;
  localparam int NW     = 31;
  localparam int PRW    = 29;
  localparam logic signed [NW-1:0] RND = NW'((1 << FRAC) - 1);
  localparam logic [SF_W:0] SF_ONE = (SF_W+1)'(1 << SF_W);

  typedef struct packed {
    logic                     pt;
    logic                     box;
    logic [SLOT_W-1:0]        slot;
    logic signed [NW-1:0]     lnum;
    logic signed [NW-1:0]     tnum;
    logic [PRW-1:0]           wprod;
    logic [PRW-1:0]           hprod;
  } raw_t;

  typedef struct packed {
    logic              pt;
    logic              box;
    logic [SLOT_W-1:0] slot;
    box_t              box_v;
  } side_t;

  // input fields
  opcode_t                   op;
  logic [CIDX_W-1:0]         f_cidx;
  logic signed [COEF_W-1:0]  f_cval;
  logic [SLOT_W-1:0]         f_slot;
  logic signed [12:0]        f_bx, f_by;
  logic [DIM_W-1:0]          f_bw, f_bh;
  logic signed [PT_W-1:0]    f_px, f_py, f_pz;

  logic adv, acc;

  logic [SF_W-1:0]  shrink_r;
  logic [CNT_W-1:0] count_r;
  logic             cfg_wr;

  raw_t  raw_r;
  raw_t  raw_nxt;
  side_t side_r [0:SIDE_N-1];
  side_t side_nxt;
  logic [27:0] sw_prod, sh_prod;

  logic signed [YW-1:0]    y0, y1, y2;
  logic signed [PIX_W-1:0] qx, qy;
  logic                    dz_x, dz_y;
  box_wr_t                 box_wr;

  logic                    res_valid;
  logic signed [PIX_W-1:0] res_px, res_py;
  status_t                 res_status;
  logic [IDX_W-1:0]        res_idx;
  logic [CNT_W-1:0]        res_count;

  logic                    out_valid_r;
  logic signed [PIX_W-1:0] out_px_r, out_py_r;
  status_t                 out_status_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic [CNT_W-1:0]        out_count_r;

  assign op     = opcode_t'(in_tuser);
  assign f_cidx = in_tdata[3:0];
  assign f_cval = in_tdata[35:4];
  assign f_slot = in_tdata[40:36];
  assign f_bx   = in_tdata[53:41];
  assign f_by   = in_tdata[66:54];
  assign f_bw   = in_tdata[78:67];
  assign f_bh   = in_tdata[90:79];
  assign f_px   = in_tdata[122:91];
  assign f_py   = in_tdata[154:123];
  assign f_pz   = in_tdata[186:155];

  // the whole pipeline moves when the result register can take a beat
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;

  // register port, always ready
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shrink_r <= SHRINK_RST;
      count_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_SHRINK: shrink_r <= cfg_pwdata[SF_W-1:0];
        REG_COUNT:  count_r  <= cfg_pwdata[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_SHRINK: cfg_prdata = 32'(shrink_r);
      REG_COUNT:  cfg_prdata = 32'(count_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // box shrink, first half: edge numerators in q.17 and scaled sizes
  always_comb begin
    sw_prod = shrink_r * f_bw;
    sh_prod = shrink_r * f_bh;
    raw_nxt.pt    = acc && (op == OP_POINT);
    raw_nxt.box   = acc && (op == OP_LOAD_BOX);
    raw_nxt.slot  = f_slot;
    raw_nxt.lnum  = (NW'(f_bx) <<< FRAC) + $signed(NW'(sw_prod));
    raw_nxt.tnum  = (NW'(f_by) <<< FRAC) + $signed(NW'(sh_prod));
    raw_nxt.wprod = f_bw * (SF_ONE - (SF_W+1)'(shrink_r));
    raw_nxt.hprod = f_bh * (SF_ONE - (SF_W+1)'(shrink_r));
  end

  // second half: truncate edges toward zero, floor the sizes
  always_comb begin
    side_nxt.pt   = raw_r.pt;
    side_nxt.box  = raw_r.box;
    side_nxt.slot = raw_r.slot;
    side_nxt.box_v.left = EDGE_W'((raw_r.lnum[NW-1] ? (raw_r.lnum + RND) : raw_r.lnum)
                                  >>> FRAC);
    side_nxt.box_v.top  = EDGE_W'((raw_r.tnum[NW-1] ? (raw_r.tnum + RND) : raw_r.tnum)
                                  >>> FRAC);
    side_nxt.box_v.width  = raw_r.wprod[SF_W+DIM_W-1:SF_W];
    side_nxt.box_v.height = raw_r.hprod[SF_W+DIM_W-1:SF_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r.pt  <= 1'b0;
      raw_r.box <= 1'b0;
      for (int i = 0; i < SIDE_N; i++) begin
        side_r[i].pt  <= 1'b0;
        side_r[i].box <= 1'b0;
      end
    end else if (adv) begin
      raw_r     <= raw_nxt;
      side_r[0] <= side_nxt;
      for (int i = 1; i < SIDE_N; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  lpba_proj u_proj (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .coef_we  (acc && (op == OP_LOAD_COEF)),
    .coef_idx (f_cidx),
    .coef_val (f_cval),
    .pt_x     (f_px),
    .pt_y     (f_py),
    .pt_z     (f_pz),
    .y0       (y0),
    .y1       (y1),
    .y2       (y2)
  );

  lpba_div u_div_x (
    .clk      (clk),
    .en       (adv),
    .num      (y0),
    .den      (y2),
    .quo      (qx),
    .den_zero (dz_x)
  );

  // same divisor as the column divider, so its zero flag is redundant
  lpba_div u_div_y (
    .clk      (clk),
    .en       (adv),
    .num      (y1),
    .den      (y2),
    .quo      (qy),
    .den_zero (dz_y)
  );

  // box loads reach the table in order with the points around them
  assign box_wr.we   = side_r[SIDE_N-1].box;
  assign box_wr.slot = side_r[SIDE_N-1].slot;
  assign box_wr.box  = side_r[SIDE_N-1].box_v;

  lpba_boxes #(
    .MAX_BOXES (MAX_BOXES)
  ) u_boxes (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .box_wr     (box_wr),
    .pt_valid   (side_r[SIDE_N-1].pt),
    .zero_depth (dz_x && dz_y),
    .px         (qx),
    .py         (qy),
    .box_count  (count_r),
    .res_valid  (res_valid),
    .res_px     (res_px),
    .res_py     (res_py),
    .res_status (res_status),
    .res_idx    (res_idx),
    .res_count  (res_count)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_px_r     <= res_px;
      out_py_r     <= res_py;
      out_status_r <= res_status;
      out_idx_r    <= res_idx;
      out_count_r  <= res_count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_count_r, out_idx_r, out_py_r, out_px_r};
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

@@ hw/rtl/lpba_proj.sv @@
// projection stages: coefficient registers, nine multipliers, row sums
// depends on lpba_pkg
`default_nettype none

module lpba_proj (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               coef_we,
  input  wire logic [lpba_pkg::CIDX_W-1:0]        coef_idx,
  input  wire logic signed [lpba_pkg::COEF_W-1:0] coef_val,
  input  wire logic signed [lpba_pkg::PT_W-1:0]   pt_x,
  input  wire logic signed [lpba_pkg::PT_W-1:0]   pt_y,
  input  wire logic signed [lpba_pkg::PT_W-1:0]   pt_z,
  output logic signed [lpba_pkg::YW-1:0]          y0,
  output logic signed [lpba_pkg::YW-1:0]          y1,
  output logic signed [lpba_pkg::YW-1:0]          y2
);
  import lpba_pkg::*;

  localparam int PW = COEF_W + PT_W;

  logic signed [COEF_W-1:0] mat_r  [0:NUM_COEF-1];
  logic signed [PW-1:0]     prod_r [0:8];
  logic signed [COEF_W-1:0] off_r  [0:2];
  logic signed [YW-1:0]     y_r    [0:2];
  logic signed [PT_W-1:0]   pt     [0:2];
  logic signed [YW-1:0]     fl     [0:8];

  always_comb begin
    pt[0] = pt_x;
    pt[1] = pt_y;
    pt[2] = pt_z;
    // arithmetic shift floors the q32.32 product to q32.16
    for (int k = 0; k < 9; k++) begin
      fl[k] = YW'(prod_r[k] >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        mat_r[k] <= '0;
      end
    end else if (coef_we && (int'(coef_idx) < NUM_COEF)) begin
      mat_r[coef_idx] <= coef_val;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r*3+c] <= PW'(mat_r[r*4+c]) * PW'(pt[c]);
        end
        off_r[r] <= mat_r[r*4+3];
        y_r[r]   <= YW'(off_r[r]) + fl[r*3] + fl[r*3+1] + fl[r*3+2];
      end
    end
  end

  assign y0 = y_r[0];
  assign y1 = y_r[1];
  assign y2 = y_r[2];

endmodule

`default_nettype wire

@@ hw/rtl/lpba_div.sv @@
// pipelined restoring divider, one quotient bit per stage, truncating and
// saturating the quotient to a 16-bit pixel; depends on lpba_pkg
`default_nettype none

module lpba_div (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [lpba_pkg::YW-1:0] num,
  input  wire logic signed [lpba_pkg::YW-1:0] den,
  output logic signed [lpba_pkg::PIX_W-1:0]   quo,
  output logic                                den_zero
);
  import lpba_pkg::*;

  localparam int TW = YW + QW;
  localparam logic [QW-1:0] POS_LIM = QW'(2**(PIX_W-1) - 1);
  localparam logic [QW-1:0] NEG_LIM = QW'(2**(PIX_W-1));

  logic [YW-1:0] rem_r [0:QW];
  logic [YW-1:0] dvs_r [0:QW];
  logic [QW-1:0] quo_r [0:QW];
  logic          neg_r [0:QW];
  logic          dz_r  [0:QW];
  logic signed [PIX_W-1:0] quo_out_r;
  logic                    dz_out_r;

  logic [TW-1:0] trial [0:QW-1];
  logic          fit   [0:QW-1];
  logic [QW-1:0] qm;
  logic signed [PIX_W-1:0] sat_q;

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      trial[j] = {{QW{1'b0}}, dvs_r[j]} << (QW - 1 - j);
      fit[j]   = ({{QW{1'b0}}, rem_r[j]} >= trial[j]);
    end
    qm = quo_r[QW];
    if (!neg_r[QW]) begin
      sat_q = (qm > POS_LIM) ? {1'b0, {(PIX_W-1){1'b1}}} : qm[PIX_W-1:0];
    end else begin
      sat_q = (qm > NEG_LIM) ? {1'b1, {(PIX_W-1){1'b0}}} : PIX_W'(-qm);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num[YW-1] ? YW'(-num) : YW'(num);
      dvs_r[0] <= den[YW-1] ? YW'(-den) : YW'(den);
      quo_r[0] <= '0;
      neg_r[0] <= num[YW-1] ^ den[YW-1];
      dz_r[0]  <= (den == '0);
      for (int j = 0; j < QW; j++) begin
        rem_r[j+1] <= fit[j] ? (rem_r[j] - trial[j][YW-1:0]) : rem_r[j];
        dvs_r[j+1] <= dvs_r[j];
        quo_r[j+1] <= {quo_r[j][QW-2:0], fit[j]};
        neg_r[j+1] <= neg_r[j];
        dz_r[j+1]  <= dz_r[j];
      end
      quo_out_r <= sat_q;
      dz_out_r  <= dz_r[QW];
    end
  end

  assign quo      = quo_out_r;
  assign den_zero = dz_out_r;

endmodule

`default_nettype wire

@@ hw/rtl/lpba_boxes.sv @@
// box table with one comparator lane per entry, then count and first hit
// depends on lpba_pkg
`default_nettype none

module lpba_boxes #(
  parameter int MAX_BOXES = lpba_pkg::MAX_BOXES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire lpba_pkg::box_wr_t                 box_wr,
  input  wire logic                              pt_valid,
  input  wire logic                              zero_depth,
  input  wire logic signed [lpba_pkg::PIX_W-1:0] px,
  input  wire logic signed [lpba_pkg::PIX_W-1:0] py,
  input  wire logic [lpba_pkg::CNT_W-1:0]        box_count,
  output logic                                   res_valid,
  output logic signed [lpba_pkg::PIX_W-1:0]      res_px,
  output logic signed [lpba_pkg::PIX_W-1:0]      res_py,
  output lpba_pkg::status_t                      res_status,
  output logic [lpba_pkg::IDX_W-1:0]             res_idx,
  output logic [lpba_pkg::CNT_W-1:0]             res_count
);
  import lpba_pkg::*;

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int XW = PIX_W + 1;

  box_t                  box_r [0:MAX_BOXES-1];
  logic [MAX_BOXES-1:0]  hit_r;
  logic                  valid_r;
  logic                  zero_r;
  logic signed [PIX_W-1:0] px_r;
  logic signed [PIX_W-1:0] py_r;

  logic [MAX_BOXES-1:0]  hit_nxt;
  logic signed [XW-1:0]  xe, ye;
  logic signed [XW-1:0]  lo_x [0:MAX_BOXES-1];
  logic signed [XW-1:0]  hi_x [0:MAX_BOXES-1];
  logic signed [XW-1:0]  lo_y [0:MAX_BOXES-1];
  logic signed [XW-1:0]  hi_y [0:MAX_BOXES-1];
  logic [CW-1:0]         pop;
  logic [AW-1:0]         first;

  // half-open containment test, one lane per table entry
  always_comb begin
    xe = XW'(px);
    ye = XW'(py);
    for (int i = 0; i < MAX_BOXES; i++) begin
      lo_x[i] = XW'(box_r[i].left);
      hi_x[i] = XW'(box_r[i].left) + $signed(XW'(box_r[i].width));
      lo_y[i] = XW'(box_r[i].top);
      hi_y[i] = XW'(box_r[i].top) + $signed(XW'(box_r[i].height));
      hit_nxt[i] = (i < int'(box_count)) && (xe >= lo_x[i]) && (xe < hi_x[i]) &&
                   (ye >= lo_y[i]) && (ye < hi_y[i]);
    end
  end

  always_comb begin
    pop   = '0;
    first = '0;
    for (int i = 0; i < MAX_BOXES; i++) begin
      pop = pop + CW'(hit_r[i]);
    end
    for (int i = MAX_BOXES - 1; i >= 0; i--) begin
      if (hit_r[i]) begin
        first = AW'(i);
      end
    end
  end

  always_comb begin
    res_valid = valid_r;
    if (zero_r) begin
      res_px     = '0;
      res_py     = '0;
      res_status = ST_ZERO_DEPTH;
      res_idx    = '0;
      res_count  = '0;
    end else begin
      res_px    = px_r;
      res_py    = py_r;
      res_count = (int'(pop) > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(pop);
      res_idx   = '0;
      if (pop == '0) begin
        res_status = ST_NONE;
      end else if (int'(pop) == 1) begin
        res_status = ST_ONE;
        res_idx    = IDX_W'(first);
      end else begin
        res_status = ST_MULTI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit_nxt;
      zero_r <= zero_depth;
      px_r   <= px;
      py_r   <= py;
      if (box_wr.we && (int'(box_wr.slot) < MAX_BOXES)) begin
        box_r[AW'(box_wr.slot)] <= box_wr.box;
      end
    end
  end

endmodule

`default_nettype wire
